@@ sv/alpd_pkg.sv @@
// Package for the ASCII length-prefixed deframer.
// Holds the beat payload types, the phase and error codes, and the field constants.
// No dependencies.
package alpd_pkg;

  // Field widths.
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 14;
  localparam int unsigned IdxW  = 12;

  // Every length field and the type field are four bytes long.
  localparam logic [1:0]      LastFieldPos = 2'd3;
  localparam logic [LenW-1:0] FieldBytes   = LenW'(4);
  localparam logic [LenW-1:0] MinFrame     = LenW'(8);

  // ASCII digit range.
  localparam logic [ByteW-1:0] AsciiZero = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine = 8'h39;

  // Decoder phase; the code doubles as the byte kind of the result.
  typedef enum logic [1:0] {
    PH_FLEN = 2'd0,
    PH_TYPE = 2'd1,
    PH_SLEN = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  // Error codes reported on the offending byte.
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_DIGIT   = 2'd1,
    ERR_SHORT   = 2'd2,
    ERR_OVERRUN = 2'd3
  } err_e;

  // Input beat payload.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
  } in_beat_t;

  // Result beat payload.
  typedef struct packed {
    logic [ByteW-1:0] echo_byte;
    logic [1:0]       byte_kind;
    logic [IdxW-1:0]  segment_index;
    logic [LenW-1:0]  segment_length;
    logic [LenW-1:0]  frame_length;
    logic             segment_end;
    logic             frame_end;
    logic [1:0]       error_code;
  } out_beat_t;

endpackage

@@ sv/alpd_if.sv @@
// Valid/ready stream interfaces for the deframer input and result channels.
// Depends on alpd_pkg for the payload types.
interface alpd_in_if;
  logic               valid;
  logic               ready;
  alpd_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface alpd_out_if;
  logic                valid;
  logic                ready;
  alpd_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/alpd_core.sv @@
// Deframer decode core: parser state registers and the per-byte next-state logic.
// Depends on alpd_pkg. The result is combinational from the state and the byte.
module alpd_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [alpd_pkg::ByteW-1:0]     data_byte_i,
  output alpd_pkg::out_beat_t            res_o
);

  alpd_pkg::phase_e              phase_q, phase_d;
  logic [1:0]                    digit_cnt_q, digit_cnt_d;
  logic [alpd_pkg::LenW-1:0]     acc_q, acc_d;
  logic [alpd_pkg::LenW-1:0]     frame_rem_q, frame_rem_d;
  logic [alpd_pkg::LenW-1:0]     seg_rem_q, seg_rem_d;
  logic [alpd_pkg::IdxW-1:0]     seg_cnt_q, seg_cnt_d;
  logic [alpd_pkg::LenW-1:0]     frame_len_q, frame_len_d;
  logic [alpd_pkg::LenW-1:0]     seg_len_q, seg_len_d;

  logic                          is_digit;
  logic                          last_of_field;
  logic [alpd_pkg::LenW-1:0]     acc_new;
  logic [alpd_pkg::LenW-1:0]     frame_rem_dec;
  logic [alpd_pkg::LenW-1:0]     seg_rem_dec;
  logic [alpd_pkg::IdxW-1:0]     idx;
  logic                          seg_end;
  logic                          frm_end;
  alpd_pkg::err_e                err;

  // Decimal accumulate: acc * 10 as two shifts, plus the digit value.
  assign is_digit = (data_byte_i >= alpd_pkg::AsciiZero) &&
                    (data_byte_i <= alpd_pkg::AsciiNine);
  assign last_of_field = (digit_cnt_q == alpd_pkg::LastFieldPos);
  assign acc_new = (acc_q << 3) + (acc_q << 1) +
                   {{(alpd_pkg::LenW-4){1'b0}}, data_byte_i[3:0]};
  assign frame_rem_dec = (frame_rem_q != '0) ? frame_rem_q - 1'b1 : frame_rem_q;
  assign seg_rem_dec   = (seg_rem_q != '0) ? seg_rem_q - 1'b1 : seg_rem_q;

  // Next state and result fields for one byte.
  always_comb begin
    phase_d     = phase_q;
    digit_cnt_d = digit_cnt_q;
    acc_d       = acc_q;
    frame_rem_d = frame_rem_q;
    seg_rem_d   = seg_rem_q;
    seg_cnt_d   = seg_cnt_q;
    frame_len_d = frame_len_q;
    seg_len_d   = seg_len_q;
    idx         = '0;
    seg_end     = 1'b0;
    frm_end     = 1'b0;
    err         = alpd_pkg::ERR_NONE;

    case (phase_q)
      alpd_pkg::PH_FLEN: begin
        // The first digit of a frame clears the per-frame report fields.
        if (digit_cnt_q == 2'd0) begin
          seg_cnt_d   = '0;
          frame_len_d = '0;
          seg_len_d   = '0;
        end
        if (!is_digit) begin
          err = alpd_pkg::ERR_DIGIT;
        end else begin
          acc_d = acc_new;
          if (!last_of_field) begin
            digit_cnt_d = digit_cnt_q + 2'd1;
          end else begin
            frame_len_d = acc_new;
            if (acc_new < alpd_pkg::MinFrame) begin
              err = alpd_pkg::ERR_SHORT;
            end else begin
              frame_rem_d = acc_new - alpd_pkg::FieldBytes;
              digit_cnt_d = 2'd0;
              acc_d       = '0;
              phase_d     = alpd_pkg::PH_TYPE;
            end
          end
        end
      end

      alpd_pkg::PH_TYPE: begin
        frame_rem_d = frame_rem_dec;
        if (!last_of_field) begin
          digit_cnt_d = digit_cnt_q + 2'd1;
        end else begin
          digit_cnt_d = 2'd0;
          if (frame_rem_dec == '0) begin
            frm_end = 1'b1;
          end else begin
            phase_d = alpd_pkg::PH_SLEN;
          end
        end
      end

      alpd_pkg::PH_SLEN: begin
        idx         = seg_cnt_q;
        frame_rem_d = frame_rem_dec;
        if (digit_cnt_q == 2'd0) begin
          seg_len_d = '0;
        end
        if (!is_digit) begin
          err = alpd_pkg::ERR_DIGIT;
        end else begin
          acc_d = acc_new;
          if (!last_of_field) begin
            // The frame may not end inside a segment length field.
            if (frame_rem_dec == '0) begin
              err = alpd_pkg::ERR_OVERRUN;
            end else begin
              digit_cnt_d = digit_cnt_q + 2'd1;
            end
          end else begin
            seg_len_d = acc_new;
            if (acc_new > frame_rem_dec) begin
              err = alpd_pkg::ERR_OVERRUN;
            end else begin
              digit_cnt_d = 2'd0;
              acc_d       = '0;
              if (acc_new == '0) begin
                // An empty segment ends on its last length digit.
                seg_end   = 1'b1;
                seg_cnt_d = seg_cnt_q + 1'b1;
                frm_end   = (frame_rem_dec == '0);
              end else begin
                seg_rem_d = acc_new;
                phase_d   = alpd_pkg::PH_BODY;
              end
            end
          end
        end
      end

      alpd_pkg::PH_BODY: begin
        idx         = seg_cnt_q;
        frame_rem_d = frame_rem_dec;
        seg_rem_d   = seg_rem_dec;
        if (seg_rem_dec == '0) begin
          seg_end   = 1'b1;
          seg_cnt_d = seg_cnt_q + 1'b1;
          if (frame_rem_dec == '0) begin
            frm_end = 1'b1;
          end else begin
            phase_d     = alpd_pkg::PH_SLEN;
            digit_cnt_d = 2'd0;
            acc_d       = '0;
          end
        end
      end

      default: begin
        phase_d = alpd_pkg::PH_FLEN;
      end
    endcase

    // After an error or a frame end, wait for the next frame length.
    if (frm_end || (err != alpd_pkg::ERR_NONE)) begin
      phase_d     = alpd_pkg::PH_FLEN;
      digit_cnt_d = 2'd0;
      acc_d       = '0;
      frame_rem_d = '0;
      seg_rem_d   = '0;
    end
  end

  // Result fields; the held lengths show their values after this byte.
  always_comb begin
    res_o.echo_byte      = data_byte_i;
    res_o.byte_kind      = phase_q;
    res_o.segment_index  = idx;
    res_o.segment_length = seg_len_d;
    res_o.frame_length   = frame_len_d;
    res_o.segment_end    = seg_end;
    res_o.frame_end      = frm_end;
    res_o.error_code     = err;
  end

  // Parser state registers, advanced once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= alpd_pkg::PH_FLEN;
      digit_cnt_q <= 2'd0;
      acc_q       <= '0;
      frame_rem_q <= '0;
      seg_rem_q   <= '0;
      seg_cnt_q   <= '0;
      frame_len_q <= '0;
      seg_len_q   <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      digit_cnt_q <= digit_cnt_d;
      acc_q       <= acc_d;
      frame_rem_q <= frame_rem_d;
      seg_rem_q   <= seg_rem_d;
      seg_cnt_q   <= seg_cnt_d;
      frame_len_q <= frame_len_d;
      seg_len_q   <= seg_len_d;
    end
  end

  // An error byte never also closes a segment or the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.error_code != alpd_pkg::ERR_NONE) |-> (!res_o.frame_end && !res_o.segment_end))
    else $error("alpd_core: error byte also flagged as an end");

  // A frame end or an error leaves the parser waiting for a new frame length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (res_o.frame_end || (res_o.error_code != alpd_pkg::ERR_NONE)))
    |=> (phase_q == alpd_pkg::PH_FLEN && digit_cnt_q == 2'd0 && acc_q == '0))
    else $error("alpd_core: parser did not return to frame length wait");

  // The last body byte of a segment is flagged as its end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == alpd_pkg::PH_BODY && seg_rem_q == alpd_pkg::LenW'(1)) |-> res_o.segment_end)
    else $error("alpd_core: last body byte not marked as segment end");

endmodule

@@ sv/ascii_length_prefixed_deframer_unit.sv @@
// Top level of the ASCII length-prefixed deframer: input register, decode core,
// result register. Depends on alpd_pkg, alpd_if.sv and alpd_core.
//
// The block takes one byte per clock while the sink keeps up, and returns exactly
// one tagged result beat for every input beat, in order. A byte moves from the
// input register through the decode core into the result register, so a result
// is presented once the result register is free or being emptied. The rate is
// one byte per cycle while the output is not stalled; it is set by the single
// decode step (a multiply-by-ten accumulate and a pair of counter decrements)
// between the two registers. The input register and the result register each hold
// a beat, so one more byte is taken while a finished result waits for the sink;
// after that the input stalls until the sink takes the result.
module ascii_length_prefixed_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  alpd_in_if.sink     in_i,
  alpd_out_if.source  out_o
);

  logic                          in_valid_q;
  logic [alpd_pkg::ByteW-1:0]    in_byte_q;
  logic                          out_valid_q;
  alpd_pkg::out_beat_t           out_q;
  alpd_pkg::out_beat_t           res;
  logic                          advance;
  logic                          in_ready;

  // The held byte moves on when the result register is free or being emptied.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_byte_q <= in_i.data.data_byte;
    end
  end

  // Decode core.
  alpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (in_byte_q),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

endmodule

@@ test/alpd_deframe_checker.sv @@
// Result checker for the ASCII length-prefixed deframer unit.
// It predicts one result beat for every accepted input beat and compares the results in order.
// Depends on alpd_pkg for the beat types, the phase and error codes, and the field constants.
module alpd_deframe_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  alpd_pkg::in_beat_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  alpd_pkg::out_beat_t out_data_i,
  output int                  mismatches_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  frames_o,
  output int                  errors_o
);
  import alpd_pkg::*;

  localparam int ReportLimit = 10;

  // Decoder state as the predictor sees it.
  phase_e          cur_phase      = PH_FLEN;
  logic [1:0]      field_pos      = '0;
  logic [LenW-1:0] len_acc        = '0;
  logic [LenW-1:0] frame_left     = '0;
  logic [LenW-1:0] seg_left       = '0;
  logic [IdxW-1:0] seg_num        = '0;
  logic [LenW-1:0] frame_len_seen = '0;
  logic [LenW-1:0] seg_len_seen   = '0;

  // Predicted result beats, oldest first.
  out_beat_t expected_results[$];

  // Drop the frame in progress and wait for a new frame length.
  task automatic go_idle();
    cur_phase  = PH_FLEN;
    field_pos  = '0;
    len_acc    = '0;
    frame_left = '0;
    seg_left   = '0;
  endtask

  // Advance the decoder by one byte and build the result beat it causes.
  task automatic deframe_byte(input logic [ByteW-1:0] b, output out_beat_t res);
    logic            is_digit;
    logic            last_pos;
    phase_e          kind;
    logic [IdxW-1:0] idx;
    logic            seg_end;
    logic            frm_end;
    err_e            err;
    is_digit = (b >= AsciiZero) && (b <= AsciiNine);
    last_pos = (field_pos == LastFieldPos);
    kind     = cur_phase;
    idx      = '0;
    seg_end  = 1'b0;
    frm_end  = 1'b0;
    err      = ERR_NONE;
    case (kind)
      PH_FLEN: begin
        // The first digit of a frame clears what the last frame reported.
        if (field_pos == 2'd0) begin
          seg_num        = '0;
          frame_len_seen = '0;
          seg_len_seen   = '0;
        end
        if (!is_digit) begin
          err = ERR_DIGIT;
          go_idle();
        end else begin
          len_acc = LenW'(len_acc * 10 + (b - AsciiZero));
          if (!last_pos) begin
            field_pos++;
          end else begin
            frame_len_seen = len_acc;
            if (len_acc < MinFrame) begin
              err = ERR_SHORT;
              go_idle();
            end else begin
              frame_left = len_acc - FieldBytes;
              field_pos  = '0;
              len_acc    = '0;
              cur_phase  = PH_TYPE;
            end
          end
        end
      end
      PH_TYPE: begin
        // Type characters are taken as they come; a frame of eight ends here.
        if (frame_left > 0) frame_left--;
        if (!last_pos) begin
          field_pos++;
        end else begin
          field_pos = '0;
          if (frame_left == 0) begin
            frm_end = 1'b1;
            go_idle();
          end else begin
            cur_phase = PH_SLEN;
          end
        end
      end
      PH_SLEN: begin
        idx = seg_num;
        if (field_pos == 2'd0) seg_len_seen = '0;
        if (frame_left > 0) frame_left--;
        if (!is_digit) begin
          err = ERR_DIGIT;
          go_idle();
        end else begin
          len_acc = LenW'(len_acc * 10 + (b - AsciiZero));
          if (!last_pos) begin
            // The frame must not end inside a segment length field.
            if (frame_left == 0) begin
              err = ERR_OVERRUN;
              go_idle();
            end else begin
              field_pos++;
            end
          end else begin
            seg_len_seen = len_acc;
            if (len_acc > frame_left) begin
              err = ERR_OVERRUN;
              go_idle();
            end else begin
              field_pos = '0;
              if (len_acc == 0) begin
                // An empty segment ends on its last length digit.
                seg_end = 1'b1;
                seg_num = seg_num + 1'b1;
                len_acc = '0;
                if (frame_left == 0) begin
                  frm_end = 1'b1;
                  go_idle();
                end
              end else begin
                seg_left  = len_acc;
                len_acc   = '0;
                cur_phase = PH_BODY;
              end
            end
          end
        end
      end
      default: begin
        idx = seg_num;
        if (frame_left > 0) frame_left--;
        if (seg_left > 0) seg_left--;
        if (seg_left == 0) begin
          seg_end = 1'b1;
          seg_num = seg_num + 1'b1;
          if (frame_left == 0) begin
            frm_end = 1'b1;
            go_idle();
          end else begin
            cur_phase = PH_SLEN;
            field_pos = '0;
            len_acc   = '0;
          end
        end
      end
    endcase
    res.echo_byte      = b;
    res.byte_kind      = kind;
    res.segment_index  = idx;
    res.segment_length = seg_len_seen;
    res.frame_length   = frame_len_seen;
    res.segment_end    = seg_end;
    res.frame_end      = frm_end;
    res.error_code     = err;
  endtask

  // Count a field that differs; the first few are reported in full.
  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      if (mismatches_o < ReportLimit) begin
        $display("Mismatch on result beat %0d, %s: expected %0d, got %0d",
                 checked_o, field, want, got);
      end
      mismatches_o++;
    end
  endtask

  // Both channels are sampled at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_beat_t want;
    out_beat_t fresh;
    if (!rst_ni) begin
      expected_results.delete();
      go_idle();
      seg_num        = '0;
      frame_len_seen = '0;
      seg_len_seen   = '0;
      pending_o      = 0;
    end else begin
      // A result beat is held against the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          if (mismatches_o < ReportLimit) begin
            $display("Result beat with no prediction waiting: byte %0d kind %0d error %0d",
                     out_data_i.echo_byte, out_data_i.byte_kind, out_data_i.error_code);
          end
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          compare_field("echo_byte", 16'(want.echo_byte), 16'(out_data_i.echo_byte));
          compare_field("byte_kind", 16'(want.byte_kind), 16'(out_data_i.byte_kind));
          compare_field("segment_index", 16'(want.segment_index),
                        16'(out_data_i.segment_index));
          compare_field("segment_length", 16'(want.segment_length),
                        16'(out_data_i.segment_length));
          compare_field("frame_length", 16'(want.frame_length),
                        16'(out_data_i.frame_length));
          compare_field("segment_end", 16'(want.segment_end), 16'(out_data_i.segment_end));
          compare_field("frame_end", 16'(want.frame_end), 16'(out_data_i.frame_end));
          compare_field("error_code", 16'(want.error_code), 16'(out_data_i.error_code));
          checked_o++;
        end
      end
      // Every accepted input beat yields exactly one prediction.
      if (in_valid_i && in_ready_i) begin
        deframe_byte(in_data_i.data_byte, fresh);
        expected_results.push_back(fresh);
        if (fresh.frame_end) frames_o++;
        if (fresh.error_code != ERR_NONE) errors_o++;
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ test/tb_ascii_length_prefixed_deframer_unit.sv @@
// Testbench top for the ASCII length-prefixed deframer unit: clock, reset, byte stimulus,
// result sink and verdict. Depends on alpd_pkg, alpd_if.sv, the unit and alpd_deframe_checker.
module tb_ascii_length_prefixed_deframer_unit;
  import alpd_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 10;
  localparam int ItemTarget    = 1425;
  localparam int HoldOffAt     = 400;
  localparam int DrainPauseAt  = 800;
  localparam int LongHold      = 300;
  localparam int DrainLimit    = 5000;
  localparam int DrainTail     = 8;
  localparam int TimeoutCycles = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;

  alpd_in_if  in_ch ();
  alpd_out_if out_ch ();

  int mismatches;
  int pending;
  int checked;
  int frames;
  int errors;

  // Sender bookkeeping and the request for a long receiver hold-off.
  int          beats_sent    = 0;
  int          burst_left    = 0;
  int          hold_requests = 0;
  int          holds_served  = 0;
  logic [7:0]  stim_q[$];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  ascii_length_prefixed_deframer_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  alpd_deframe_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .frames_o     (frames),
    .errors_o     (errors)
  );

  // ASCII digit of a value at one of the four places, most significant first.
  function automatic logic [7:0] ascii_digit(input int unsigned value, input int unsigned place);
    int unsigned scale;
    scale = 1;
    repeat (3 - place) scale = scale * 10;
    return 8'(AsciiZero + (value / scale) % 10);
  endfunction

  // A random byte outside the digit range.
  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b >= AsciiZero && b <= AsciiNine);
    return b;
  endfunction

  task automatic append_field(input int unsigned value);
    for (int i = 0; i < 4; i++) stim_q.push_back(ascii_digit(value, i));
  endtask

  task automatic append_random(input int unsigned count);
    repeat (count) stim_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) stim_q.push_back(s[i]);
  endtask

  // Queue one frame: mostly well formed, the rest broken in one of several ways or noise.
  task automatic queue_random_frame();
    int unsigned shape;
    int unsigned nseg;
    int unsigned total;
    int unsigned new_total;
    int unsigned start;
    int unsigned n;
    int unsigned r;
    int unsigned k;
    bit          all_empty;
    int unsigned seg_len[48];
    int unsigned seg_pos[48];
    shape = $urandom_range(0, 99);
    if (shape >= 97) begin
      // Raw noise between frames.
      append_random($urandom_range(1, 8));
    end else if (shape >= 93) begin
      // Any frame length, then a broken segment length to get back in step.
      append_field($urandom_range(0, 9999));
      append_random(4);
      stim_q.push_back(non_digit());
    end else if (shape >= 89) begin
      // Any segment length inside a small frame; mostly an overrun.
      n = $urandom_range(0, 6);
      append_field(12 + n);
      append_random(4);
      append_field($urandom_range(0, 9999));
      append_random(n);
    end else if (shape >= 83) begin
      // Frame length under the minimum.
      append_field($urandom_range(0, 7));
    end else begin
      all_empty = ($urandom_range(0, 19) == 0);
      nseg = all_empty ? $urandom_range(10, 40) : $urandom_range(0, 5);
      if (shape >= 64 && nseg == 0) nseg = 1;
      total = 8;
      for (int i = 0; i < nseg; i++) begin
        r = $urandom_range(0, 9);
        if (all_empty || r < 2) seg_len[i] = 0;
        else if (r < 8) seg_len[i] = $urandom_range(1, 8);
        else if (r < 9) seg_len[i] = $urandom_range(9, 40);
        else seg_len[i] = $urandom_range(41, 120);
        total += 4 + seg_len[i];
      end
      start = stim_q.size();
      append_field(total);
      append_random(4);
      for (int i = 0; i < nseg; i++) begin
        seg_pos[i] = stim_q.size();
        append_field(seg_len[i]);
        append_random(seg_len[i]);
      end
      if (shape >= 76) begin
        // Frame length too small for its segments: overrun or a cut length field.
        new_total = $urandom_range(8, total - 1);
        for (int i = 0; i < 4; i++) stim_q[start + i] = ascii_digit(new_total, i);
      end else if (shape >= 70) begin
        k = $urandom_range(0, nseg - 1);
        stim_q[seg_pos[k] + $urandom_range(0, 3)] = non_digit();
      end else if (shape >= 64) begin
        stim_q[start + $urandom_range(0, 3)] = non_digit();
      end
    end
  endtask

  // Offer one byte and wait for its handshake; bursts alternate with idle gaps.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(100, 300);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        in_ch.data.data_byte <= 8'($urandom_range(0, 255));
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data.data_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    burst_left--;
    beats_sent++;
  endtask

  // Send everything queued, asking for the hold-off and the drain pause on the way.
  task automatic send_queued(inout bit hold_done, inout bit drain_done);
    logic [7:0] b;
    while (stim_q.size() != 0) begin
      if (!hold_done && beats_sent >= HoldOffAt) begin
        hold_done = 1'b1;
        hold_requests++;
      end
      if (!drain_done && beats_sent >= DrainPauseAt) begin
        drain_done = 1'b1;
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      b = stim_q.pop_front();
      send_byte(b);
    end
  endtask

  // Result sink: stretches of different stall patterns, and a long hold-off on request.
  initial begin : result_sink
    int unsigned mode;
    int unsigned stretch;
    int unsigned period;
    int unsigned tick;
    mode = 0;
    stretch = 0;
    period = 2;
    tick = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        holds_served++;
      end
      if (stretch == 0) begin
        mode = $urandom_range(0, 3);
        stretch = $urandom_range(20, 200);
        period = $urandom_range(2, 5);
      end
      stretch--;
      tick++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (tick % period == 0);
      endcase
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int  waited;
    bit  hold_done;
    bit  drain_done;
    hold_done = 1'b0;
    drain_done = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames: type bytes at both extremes ending on an empty segment,
    // a frame of exactly eight, a short frame, and a non-digit frame length.
    queue_text("0012");
    stim_q.push_back(8'h00);
    stim_q.push_back(8'hFF);
    stim_q.push_back(8'h2F);
    stim_q.push_back(8'h3A);
    queue_text("0000");
    queue_text("0008ABCD");
    queue_text("0007");
    queue_text("0/");
    send_queued(hold_done, drain_done);

    // Random frames until enough beats have gone in.
    while (beats_sent < ItemTarget) begin
      queue_random_frame();
      send_queued(hold_done, drain_done);
    end

    // Let the last results come out.
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DrainTail) @(negedge clk_i);
    if (pending != 0) $display("%0d predicted result beats never arrived", pending);
    $display("Covered %0d input beats and %0d checked results: %0d frames closed, %0d error beats.",
             beats_sent, checked, frames, errors);
    if (mismatches == 0 && pending == 0) begin
      $display("ascii_length_prefixed_deframer_unit test passed");
    end else begin
      $display("ascii_length_prefixed_deframer_unit test failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #(TimeoutCycles * ClkPeriod);
    $display("Timeout after %0d cycles with %0d beats sent", TimeoutCycles, beats_sent);
    $display("ascii_length_prefixed_deframer_unit test failed");
    $finish;
  end

endmodule
